// File: rtl/core/mad_pkg.sv
// Package for the motion activity detector: shared types, register codes,
// reset values and recovery-sequence constants. No dependencies.
`default_nettype none

package mad_pkg;

    // Configuration port.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SCALE_FACTOR     = 2'd0,
        CFG_WINDOW_LENGTH    = 2'd1,
        CFG_MOTION_THRESHOLD = 2'd2,
        CFG_EXPECTED_ID      = 2'd3
    } cfg_index_t;

    localparam logic [15:0] SCALE_FACTOR_RST     = 16'd3998;
    localparam logic [3:0]  WINDOW_LENGTH_RST    = 4'd10;
    localparam logic [15:0] MOTION_THRESHOLD_RST = 16'd40;
    localparam logic [7:0]  EXPECTED_ID_RST      = 8'd68;

    // Identity-error recovery sequence thresholds.
    localparam logic [5:0] ID_OFF_AFTER   = 6'd20;
    localparam logic [5:0] ID_ON_FROM     = 6'd25;
    localparam logic [5:0] ID_REINIT_FROM = 6'd35;

    localparam logic [11:0] MAG_MAX = 12'd4095;

    typedef enum logic [1:0] {
        PWR_NONE   = 2'd0,
        PWR_OFF    = 2'd1,
        PWR_ON     = 2'd2,
        PWR_REINIT = 2'd3
    } pwr_action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MULT,
        ST_SQRT,
        ST_UPDATE
    } mad_state_t;

    typedef struct packed {
        logic [11:0] magnitude;
        logic        window_done;
        logic        motion_detected;
        pwr_action_t power_action;
    } mad_result_t;

endpackage

`default_nettype wire

// File: rtl/core/motion_activity_detector.sv
// Top level of the motion activity detector: configuration registers, the
// sequencer and the output register. Depends on mad_pkg, mad_mul_acc,
// mad_isqrt and mad_window.
//
// Usage: one input transaction carries a raw three-axis sample and the
// sensor identity byte; it is accepted when in_valid is high and in_stall
// is low. Exactly one output transaction follows, carrying the magnitude,
// the window-done mark, the held motion flag and the power action; it is
// taken when out_valid is high and out_stall is low.
// After acceptance the shared multiplier runs three scalings and three squares,
// the square root yields one root bit per cycle or saturates without iterating,
// and the commit step updates the window state. in_stall is high from acceptance
// until that commit, so a new sample waits until the last one has committed.
// Configuration is written through cfg_we, cfg_index and cfg_data; the user must
// write it only while idle, as the block itself does not enforce this.
// The output register parts the two channels: a new sample may be accepted
// while a result waits. If the receiver stalls, the next result waits in the
// commit step until the output register is free.
// Reset (rst_n, asynchronous, active low) restores the default configuration
// and clears the window, motion and identity-error state.
`default_nettype none

module motion_activity_detector (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [mad_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mad_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic signed [15:0]              accel_x,
    input  logic signed [15:0]              accel_y,
    input  logic signed [15:0]              accel_z,
    input  logic [7:0]                      device_id,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [11:0]                     magnitude,
    output logic                            window_done,
    output logic                            motion_detected,
    output logic [1:0]                      power_action
);
    import mad_pkg::*;

    // Configuration registers.
    logic [15:0] scale_factor_reg;
    logic [3:0]  window_length_reg;
    logic [15:0] motion_threshold_reg;
    logic [7:0]  expected_id_reg;

    // Captured input transaction.
    logic signed [15:0] ax_reg, ay_reg, az_reg;
    logic [7:0]         id_reg;

    mad_state_t  state_reg, state_next;
    logic        accept;
    logic        mul_start, mul_done;
    logic        sqrt_start, sqrt_done;
    logic        commit;
    logic        out_free;
    logic [31:0] sum_sq;
    logic [11:0] root;
    mad_result_t win_result;
    mad_result_t out_res_reg;
    logic        out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_factor_reg     <= SCALE_FACTOR_RST;
            window_length_reg    <= WINDOW_LENGTH_RST;
            motion_threshold_reg <= MOTION_THRESHOLD_RST;
            expected_id_reg      <= EXPECTED_ID_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SCALE_FACTOR:     scale_factor_reg     <= cfg_data[15:0];
                CFG_WINDOW_LENGTH:    window_length_reg    <= cfg_data[3:0];
                CFG_MOTION_THRESHOLD: motion_threshold_reg <= cfg_data[15:0];
                CFG_EXPECTED_ID:      expected_id_reg      <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Only the idle state takes a new sample.
    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ax_reg <= accel_x;
            ay_reg <= accel_y;
            az_reg <= accel_z;
            id_reg <= device_id;
        end
    end

    // Sequencer: next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_MULT;
                end
            end
            ST_MULT:
            begin
                if (mul_done)
                begin
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                if (sqrt_done)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer: control strobes.
    always_comb
    begin
        mul_start  = 1'b0;
        sqrt_start = 1'b0;
        commit     = 1'b0;
        case (state_reg)
            ST_IDLE:   mul_start  = accept;
            ST_MULT:   sqrt_start = mul_done;
            ST_UPDATE: commit     = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    mad_mul_acc u_mul_acc (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (mul_start),
        .scale_factor (scale_factor_reg),
        .accel_x      (ax_reg),
        .accel_y      (ay_reg),
        .accel_z      (az_reg),
        .done         (mul_done),
        .sum_sq       (sum_sq)
    );

    mad_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (sum_sq),
        .done     (sqrt_done),
        .root     (root)
    );

    mad_window u_window (
        .clk              (clk),
        .rst_n            (rst_n),
        .update           (commit),
        .magnitude        (root),
        .device_id        (id_reg),
        .window_length    (window_length_reg),
        .motion_threshold (motion_threshold_reg),
        .expected_id      (expected_id_reg),
        .result           (win_result)
    );

    // Output register.
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            out_res_reg <= win_result;
        end
    end

    assign out_valid       = out_valid_reg;
    assign magnitude       = out_res_reg.magnitude;
    assign window_done     = out_res_reg.window_done;
    assign motion_detected = out_res_reg.motion_detected;
    assign power_action    = out_res_reg.power_action;

    // A new result appears only from the commit step.
    a_out_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_UPDATE))
        else $error("output became valid outside the commit step");

    // The multiplier finishes only while the sequencer waits for it.
    a_mul_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == ST_MULT))
        else $error("multiplier finished outside the multiply state");

    // The square root finishes only while the sequencer waits for it.
    a_sqrt_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        sqrt_done |-> (state_reg == ST_SQRT))
        else $error("square root finished outside the root state");

    // A power action is only reported on a sample that closes a window.
    a_action_on_close: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && (win_result.power_action != PWR_NONE)) |-> win_result.window_done)
        else $error("power action without a window close");

endmodule

`default_nettype wire

// File: rtl/core/mad_mul_acc.sv
// Shared multiplier unit: scales the three axes to milli-g, then squares and
// accumulates them into the sum of squares. Depends on mad_pkg.
`default_nettype none

module mad_mul_acc (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [15:0]        scale_factor,
    input  logic signed [15:0] accel_x,
    input  logic signed [15:0] accel_y,
    input  logic signed [15:0] accel_z,
    output logic               done,
    output logic [31:0]        sum_sq
);
    import mad_pkg::*;

    logic        busy_reg, busy_next;
    logic [2:0]  step_reg, step_next;
    logic        done_reg, done_next;
    logic [30:0] prod_reg;
    logic [14:0] mg_x_reg, mg_y_reg, mg_z_reg;
    logic [31:0] sum_reg;
    logic [16:0] op_a;
    logic [15:0] op_b;
    logic [32:0] mult_full;
    logic [14:0] mg_sel;

    function automatic logic [16:0] abs17(input logic signed [15:0] v);
        logic [16:0] ext;
        ext = {v[15], v};
        return v[15] ? (17'd0 - ext) : ext;
    endfunction

    // Operand selection: steps 0 to 2 scale an axis, steps 3 to 5 square one.
    always_comb
    begin
        case (step_reg)
            3'd3:    mg_sel = mg_x_reg;
            3'd4:    mg_sel = mg_y_reg;
            default: mg_sel = mg_z_reg;
        endcase
        case (step_reg)
            3'd0:
            begin
                op_a = abs17(accel_x);
                op_b = scale_factor;
            end
            3'd1:
            begin
                op_a = abs17(accel_y);
                op_b = scale_factor;
            end
            3'd2:
            begin
                op_a = abs17(accel_z);
                op_b = scale_factor;
            end
            default:
            begin
                op_a = {2'b00, mg_sel};
                op_b = {1'b0, mg_sel};
            end
        endcase
    end

    assign mult_full = {16'd0, op_a} * {17'd0, op_b};

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = 3'd0;
        end
        else if (busy_reg)
        begin
            step_next = step_reg + 3'd1;
            if (step_reg == 3'd6)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= 3'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    // Datapath: the product is registered before the next step consumes it.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sum_reg <= 32'd0;
        end
        else if (busy_reg)
        begin
            if (step_reg <= 3'd5)
            begin
                prod_reg <= mult_full[30:0];
            end
            case (step_reg)
                3'd1:    mg_x_reg <= prod_reg[30:16];
                3'd2:    mg_y_reg <= prod_reg[30:16];
                3'd3:    mg_z_reg <= prod_reg[30:16];
                3'd4,
                3'd5,
                3'd6:    sum_reg <= sum_reg + {1'b0, prod_reg};
                default: ;
            endcase
        end
    end

    assign done   = done_reg;
    assign sum_sq = sum_reg;

endmodule

`default_nettype wire

// File: rtl/core/mad_isqrt.sv
// Bit-serial integer square root, one root bit per cycle, saturating at the
// largest 12-bit magnitude. Depends on mad_pkg.
`default_nettype none

module mad_isqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] radicand,
    output logic        done,
    output logic [11:0] root
);
    import mad_pkg::*;

    logic        busy_reg;
    logic        done_reg;
    logic [3:0]  cnt_reg;
    logic [23:0] n_reg;
    logic [13:0] rem_reg;
    logic [11:0] root_reg;
    logic [15:0] shifted;
    logic [13:0] trial;
    logic        take;

    assign shifted = {rem_reg, n_reg[23:22]};
    assign trial   = {root_reg, 2'b01};
    assign take    = (shifted >= {2'b00, trial});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 4'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= 4'd0;
                if (radicand[31:24] != 8'd0)
                begin
                    done_reg <= 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b1;
                end
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == 4'd11)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg   <= radicand[23:0];
            rem_reg <= 14'd0;
            // A radicand of 2^24 or more has a root above the 12-bit range.
            root_reg <= (radicand[31:24] != 8'd0) ? MAG_MAX : 12'd0;
        end
        else if (busy_reg)
        begin
            n_reg <= {n_reg[21:0], 2'b00};
            if (take)
            begin
                rem_reg  <= 14'(shifted - {2'b00, trial});
                root_reg <= {root_reg[10:0], 1'b1};
            end
            else
            begin
                rem_reg  <= shifted[13:0];
                root_reg <= {root_reg[10:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

// File: rtl/core/mad_window.sv
// Window accumulation, motion decision and identity-error recovery state.
// Computes the result for the current sample and commits on update. Depends on mad_pkg.
`default_nettype none

module mad_window (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 update,
    input  logic [11:0]          magnitude,
    input  logic [7:0]           device_id,
    input  logic [3:0]           window_length,
    input  logic [15:0]          motion_threshold,
    input  logic [7:0]           expected_id,
    output mad_pkg::mad_result_t result
);
    import mad_pkg::*;

    logic [11:0] prev_mag_reg;
    logic [15:0] sum_reg, sum_next;
    logic [3:0]  count_reg, count_next;
    logic [5:0]  err_reg, err_next;
    logic        motion_reg, motion_next;
    logic [11:0] diff;
    logic [16:0] sum_ext;
    logic [15:0] sum_sat;
    logic [3:0]  cnt_inc;
    logic [5:0]  err_inc;
    logic        close;
    pwr_action_t action;

    always_comb
    begin
        diff    = (magnitude >= prev_mag_reg) ? (magnitude - prev_mag_reg)
                                              : (prev_mag_reg - magnitude);
        sum_ext = {1'b0, sum_reg} + {5'd0, diff};
        sum_sat = sum_ext[16] ? 16'hFFFF : sum_ext[15:0];
        cnt_inc = count_reg + 4'd1;
        err_inc = err_reg + 6'd1;
        close   = (cnt_inc >= window_length);

        sum_next    = sum_sat;
        count_next  = cnt_inc;
        err_next    = err_reg;
        motion_next = motion_reg;
        action      = PWR_NONE;

        if (close)
        begin
            sum_next    = 16'd0;
            count_next  = 4'd0;
            motion_next = (sum_sat > motion_threshold);
            if (device_id != expected_id)
            begin
                err_next = err_inc;
                if (err_inc inside {[ID_OFF_AFTER + 6'd1 : ID_ON_FROM - 6'd1]})
                begin
                    action = PWR_OFF;
                end
                else if (err_inc inside {[ID_ON_FROM : ID_REINIT_FROM - 6'd1]})
                begin
                    action = PWR_ON;
                end
                else if (err_inc >= ID_REINIT_FROM)
                begin
                    action   = PWR_REINIT;
                    err_next = 6'd0;
                end
            end
            else
            begin
                err_next = 6'd0;
            end
        end

        result.magnitude       = magnitude;
        result.window_done     = close;
        result.motion_detected = motion_next;
        result.power_action    = action;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_mag_reg <= 12'd0;
            sum_reg      <= 16'd0;
            count_reg    <= 4'd0;
            err_reg      <= 6'd0;
            motion_reg   <= 1'b0;
        end
        else if (update)
        begin
            prev_mag_reg <= magnitude;
            sum_reg      <= sum_next;
            count_reg    <= count_next;
            err_reg      <= err_next;
            motion_reg   <= motion_next;
        end
    end

endmodule

`default_nettype wire
